>>> hdl/stg_pkg.sv
// Shared types, constants and the quarter-wave sine table of the tone generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package stg_pkg;

  // Quarter-wave table geometry, fixed by the Q1.15 sample format
  localparam int TAB_ADDR_BITS = 8;
  localparam int TAB_SIZE      = (1 << TAB_ADDR_BITS) + 1;
  localparam int TAB_IDX_W     = TAB_ADDR_BITS + 1;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Field widths
  localparam int STEP_W   = 32;
  localparam int VOL_W    = 15;
  localparam int CCOUNT_W = 4;
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 15;
  localparam int CHIDX_W  = 3;

  // Register reset values
  localparam logic [STEP_W-1:0]   PHASE_STEP_RST    = 32'd23371780;
  localparam logic [VOL_W-1:0]    VOLUME_RST        = 15'd25000;
  localparam logic [CCOUNT_W-1:0] CHANNEL_COUNT_RST = 4'd2;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_PHASE_STEP    = 2'd0,
    REG_VOLUME        = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } stg_reg_t;

  // Configuration register bundle
  typedef struct packed {
    logic [STEP_W-1:0]   phase_step;
    logic [VOL_W-1:0]    volume;
    logic [CCOUNT_W-1:0] channel_count;
  } stg_cfg_t;

  typedef logic [MAG_W-1:0] sine_tab_t [0:TAB_SIZE-1];

  // Taylor term divisor (2n)(2n+1)
  function automatic logic [63:0] term_div(input logic [63:0] term, input int n);
    logic [63:0] q;
    q = term;
    unique case (n)
      1: q = term / 6;
      2: q = term / 20;
      3: q = term / 42;
      4: q = term / 72;
      5: q = term / 110;
      6: q = term / 156;
      7: q = term / 210;
      default: q = term;
    endcase
    return q;
  endfunction

  // Builds the quarter-wave table at elaboration: Q30 Taylor series to t^15,
  // truncated products, then scaled to 32767 with round half up.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] t;
    logic [63:0] term;
    longint      sum;
    logic [63:0] v;
    for (int k = 0; k < TAB_SIZE; k++) begin
      t    = (64'(k) * HALF_PI_Q30) >> TAB_ADDR_BITS;
      term = t;
      sum  = longint'(t);
      for (int n = 1; n <= 7; n++) begin
        term = (term * t) >> 30;
        term = (term * t) >> 30;
        term = term_div(term, n);
        if ((n % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = ((64'(sum) * 64'd32767) + 64'd536870912) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      tab[k] = MAG_W'(v);
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

>>> hdl/sine_tone_generator_core.sv
// Top level of the DDS sine tone generator: configuration registers, front
// end, job queue and channel back end. Depends on stg_pkg, stg_front,
// stg_queue and stg_back.
//
//   channel  | direction | beat contents
//   ---------+-----------+----------------------------------------------
//   in_      | input     | frame_request (1 asks for one frame)
//   out_     | output    | sample_value, channel_index, last_of_frame
//   cfg_     | input     | cfg_we, cfg_index, cfg_data (write only)
//
// The front end registers the table read for a frame, then the scaled
// sample enters a two-entry queue; the back end sends one beat per cycle
// while out_ready is high, one beat per channel of the frame.
// Requests are taken back to back while the queue has room. Reset is
// synchronous; it clears the phase, the queue and the output valid flag.
// Either side may stall at any time without losing or repeating a beat.
`default_nettype none

module sine_tone_generator_core
  import stg_pkg::*;
#(
  parameter int MAX_CHANNELS = 8,
  parameter int PHASE_BITS   = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [STEP_W-1:0]     cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_frame_request,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_value,
  output logic [CHIDX_W-1:0]         out_channel_index,
  output logic                       out_last_of_frame
);

  localparam int NCH_W  = $clog2(MAX_CHANNELS + 1);
  localparam int DATA_W = SAMPLE_W + NCH_W;

  stg_cfg_t cfg_r, cfg_nxt;

  logic                       job_valid, job_ready;
  logic signed [SAMPLE_W-1:0] job_sample;
  logic [NCH_W-1:0]           job_nch;
  logic                       head_valid, pop;
  logic [DATA_W-1:0]          head_data;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (stg_reg_t'(cfg_index))
        REG_PHASE_STEP:    cfg_nxt.phase_step    = cfg_data;
        REG_VOLUME:        cfg_nxt.volume        = cfg_data[VOL_W-1:0];
        REG_CHANNEL_COUNT: cfg_nxt.channel_count = cfg_data[CCOUNT_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step    <= PHASE_STEP_RST;
      cfg_r.volume        <= VOLUME_RST;
      cfg_r.channel_count <= CHANNEL_COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  stg_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .PHASE_BITS   (PHASE_BITS),
    .NCH_W        (NCH_W)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_frame_request (in_frame_request),
    .job_valid        (job_valid),
    .job_ready        (job_ready),
    .job_sample       (job_sample),
    .job_nch          (job_nch)
  );

  stg_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_valid),
    .push_data  ({job_sample, job_nch}),
    .push_ready (job_ready),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  stg_back #(
    .NCH_W (NCH_W)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head_sample       ($signed(head_data[DATA_W-1 -: SAMPLE_W])),
    .head_nch          (head_data[NCH_W-1:0]),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_value  (out_sample_value),
    .out_channel_index (out_channel_index),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

`default_nettype wire

>>> hdl/stg_queue.sv
// Small FIFO carrying frame jobs from the front to the back.
// Depends on stg_pkg (QUEUE_DEPTH).
`default_nettype none

module stg_queue
  import stg_pkg::*;
#(
  parameter int DATA_W = 20
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   push_ready,
  output logic                   head_valid,
  output logic [DATA_W-1:0]      head_data,
  input  wire logic              pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] entries_r [0:QUEUE_DEPTH-1];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_wr, do_rd;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = entries_r[rd_ptr_r];

  assign do_wr = push && push_ready;
  assign do_rd = pop && head_valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> hdl/stg_front.sv
// Front end: accepts frame requests, keeps the phase accumulator, looks up the
// sine table and scales by volume, then pushes one job per frame. Uses stg_pkg.
`default_nettype none

module stg_front
  import stg_pkg::*;
#(
  parameter int MAX_CHANNELS = 8,
  parameter int PHASE_BITS   = 32,
  parameter int NCH_W        = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire stg_cfg_t            cfg,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_frame_request,
  output logic                     job_valid,
  input  wire logic                job_ready,
  output logic signed [SAMPLE_W-1:0] job_sample,
  output logic [NCH_W-1:0]         job_nch
);

  localparam sine_tab_t SINE_TAB = build_sine_tab();
  localparam int IDX_LSB = PHASE_BITS - 2 - TAB_ADDR_BITS;

  logic [PHASE_BITS-1:0]  phase_acc_r, phase_acc_nxt;
  logic [PHASE_BITS-1:0]  step;
  logic [1:0]             quad;
  logic [TAB_IDX_W-1:0]   tab_idx;
  logic [NCH_W-1:0]       nch;
  logic                   accept, take;

  // Lookup stage registers
  logic                   lk_valid_r, lk_valid_nxt;
  logic [MAG_W-1:0]       lk_mag_r;
  logic                   lk_neg_r;
  logic [NCH_W-1:0]       lk_nch_r;

  logic [2*MAG_W-1:0]     prod;
  logic [SAMPLE_W-1:0]    mag_scaled;

  // Phase step scaled to the accumulator width
  generate
    if (PHASE_BITS >= STEP_W) begin : g_step_up
      assign step = PHASE_BITS'(cfg.phase_step) << (PHASE_BITS - STEP_W);
    end else begin : g_step_dn
      assign step = PHASE_BITS'(cfg.phase_step >> (STEP_W - PHASE_BITS));
    end
  endgenerate

  // Quadrant and table address from the current phase
  assign quad    = phase_acc_r[PHASE_BITS-1 -: 2];
  always_comb begin
    tab_idx = {1'b0, phase_acc_r[IDX_LSB +: TAB_ADDR_BITS]};
    if (quad[0]) begin
      tab_idx = TAB_IDX_W'(1 << TAB_ADDR_BITS) - tab_idx;
    end
  end

  // Channel count clamped to 1..MAX_CHANNELS
  always_comb begin
    if (cfg.channel_count == '0) begin
      nch = NCH_W'(1);
    end else if ({1'b0, cfg.channel_count} > (CCOUNT_W + 1)'(MAX_CHANNELS)) begin
      nch = NCH_W'(MAX_CHANNELS);
    end else begin
      nch = NCH_W'(cfg.channel_count);
    end
  end

  // Handshake: lookup stage advances when the queue takes its job
  assign job_valid = lk_valid_r;
  assign take      = lk_valid_r && job_ready;
  assign in_ready  = !lk_valid_r || job_ready;
  assign accept    = in_valid && in_ready && in_frame_request;

  always_comb begin
    lk_valid_nxt  = lk_valid_r;
    phase_acc_nxt = phase_acc_r;
    if (take) begin
      lk_valid_nxt = 1'b0;
    end
    if (accept) begin
      lk_valid_nxt  = 1'b1;
      phase_acc_nxt = phase_acc_r + step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_valid_r  <= 1'b0;
      phase_acc_r <= '0;
    end else begin
      lk_valid_r  <= lk_valid_nxt;
      phase_acc_r <= phase_acc_nxt;
    end
  end

  // Table read registered with sign and channel count
  always_ff @(posedge clk) begin
    if (accept) begin
      lk_mag_r <= SINE_TAB[tab_idx];
      lk_neg_r <= quad[1];
      lk_nch_r <= nch;
    end
  end

  // Volume scaling, truncation toward zero on the magnitude
  assign prod       = lk_mag_r * cfg.volume;
  assign mag_scaled = {1'b0, prod[2*MAG_W-1 -: MAG_W]};
  assign job_sample = lk_neg_r ? -$signed(mag_scaled) : $signed(mag_scaled);
  assign job_nch    = lk_nch_r;

endmodule

`default_nettype wire

>>> hdl/stg_back.sv
// Back end: replays one queued sample over the frame's channels into the
// output register. Uses stg_pkg.
`default_nettype none

module stg_back
  import stg_pkg::*;
#(
  parameter int NCH_W = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  head_valid,
  input  wire logic signed [SAMPLE_W-1:0] head_sample,
  input  wire logic [NCH_W-1:0]      head_nch,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_value,
  output logic [CHIDX_W-1:0]         out_channel_index,
  output logic                       out_last_of_frame
);

  logic [NCH_W-1:0]           ch_r, ch_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [CHIDX_W-1:0]         chidx_r;
  logic                       last_r;
  logic                       load, last;

  // Load a beat when the output register is free or draining
  assign load = head_valid && (!out_valid_r || out_ready);
  assign last = ({1'b0, ch_r} + 1'b1) == {1'b0, head_nch};
  assign pop  = load && last;

  always_comb begin
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      ch_nxt        = last ? '0 : ch_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      sample_r <= head_sample;
      chidx_r  <= CHIDX_W'(ch_r);
      last_r   <= last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample_value  = sample_r;
  assign out_channel_index = chidx_r;
  assign out_last_of_frame = last_r;

endmodule

`default_nettype wire

>>> tb/tb_sine_tone_generator_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for sine_tone_generator_core: a directed table, then
// random register settings and frame requests, checked against a local predictor.
// Depends on stg_pkg and the RTL of the tone generator only.

module tb_sine_tone_generator_core;
  import stg_pkg::*;

  localparam int          MAX_CH        = 8;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          SQUEEZE_HOLD  = 400;
  localparam int          RANDOM_FRAMES = 170;
  localparam logic [63:0] PI_HALF_Q30   = 64'd1686629713;

  // One output beat: what the block should send for one channel of a frame
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CHIDX_W-1:0]         chan;
    logic                       last;
  } tone_beat_t;

  typedef enum logic {
    ROW_FRAME = 1'b0,
    ROW_WRITE = 1'b1
  } row_kind_t;

  // Directed row: a register write or a frame beat, with an optional pinned sample
  typedef struct packed {
    row_kind_t                  kind;
    stg_reg_t                   reg_sel;
    logic [STEP_W-1:0]          wdata;
    logic                       req;
    logic                       pinned;
    logic signed [SAMPLE_W-1:0] pin_val;
  } dir_row_t;

  localparam int DIR_COUNT = 37;

  // Phase walk: two default steps, then a step that lands exactly on a quarter
  // cycle, so the quadrant peaks and zero crossings can be pinned by hand.
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b1, 1'b1, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b1, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_PHASE_STEP,    32'd1026998264, 1'b0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_VOLUME,        32'd32767,      1'b0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_CHANNEL_COUNT, 32'd8,          1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b1, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_PHASE_STEP,    32'h40000000,   1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b1, 1'b1, 16'sd32766},
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b1, 1'b1, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b1, 1'b1, -16'sd32766},
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b1, 1'b1, 16'sd0},
    '{ROW_WRITE, REG_CHANNEL_COUNT, 32'd0,          1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b1, 1'b1, 16'sd32766},
    '{ROW_WRITE, REG_CHANNEL_COUNT, 32'd15,         1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b1, 1'b1, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b1, 1'b1, -16'sd32766},
    '{ROW_WRITE, REG_VOLUME,        32'd0,          1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b1, 1'b1, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b1, 1'b1, 16'sd0},
    '{ROW_WRITE, REG_VOLUME,        32'd32767,      1'b0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_PHASE_STEP,    32'hFFFFFFFF,   1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b1, 1'b1, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b1, 1'b0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b1, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_CHANNEL_COUNT, 32'd1,          1'b0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_PHASE_STEP,    32'd0,          1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b1, 1'b0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b1, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_CHANNEL_COUNT, 32'd3,          1'b0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_VOLUME,        32'd12345,      1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b1, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_PHASE_STEP,    32'h00C00000,   1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b1, 1'b0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP,    32'd0,          1'b1, 1'b0, 16'sd0}
  };

  // DUT ports
  logic                       clk               = 1'b0;
  logic                       rst_n             = 1'b0;
  logic                       cfg_we            = 1'b0;
  logic [1:0]                 cfg_index         = 2'd0;
  logic [STEP_W-1:0]          cfg_data          = '0;
  logic                       in_valid          = 1'b0;
  logic                       in_ready;
  logic                       in_frame_request  = 1'b0;
  logic                       out_valid;
  logic                       out_ready         = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_value;
  logic [CHIDX_W-1:0]         out_channel_index;
  logic                       out_last_of_frame;

  // Predictor state: phase accumulator and register shadows
  logic [31:0]         tone_phase  = '0;
  logic [STEP_W-1:0]   tone_step   = PHASE_STEP_RST;
  logic [VOL_W-1:0]    tone_volume = VOLUME_RST;
  logic [CCOUNT_W-1:0] tone_chans  = CHANNEL_COUNT_RST;
  logic [MAG_W-1:0]    quarter_sine [0:TAB_SIZE-1];

  tone_beat_t pending_beats [$];
  int         fail_cnt     = 0;
  int         rx_beats     = 0;
  int         cycle_cnt    = 0;
  bit         squeeze_req  = 1'b0;
  bit         squeeze_done = 1'b0;

  sine_tone_generator_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_frame_request  (in_frame_request),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_value  (out_sample_value),
    .out_channel_index (out_channel_index),
    .out_last_of_frame (out_last_of_frame)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Quarter-wave sine in Q1.15: Q30 Taylor series to t^15, truncated products
  initial begin : build_quarter_sine
    logic [63:0] t;
    logic [63:0] term;
    longint      acc;
    logic [63:0] v;
    for (int k = 0; k < TAB_SIZE; k++) begin
      t    = (64'(k) * PI_HALF_Q30) >> TAB_ADDR_BITS;
      term = t;
      acc  = longint'(t);
      for (int n = 1; n <= 7; n++) begin
        term = (term * t) >> 30;
        term = (term * t) >> 30;
        term = term / (64'(2 * n) * 64'(2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      v = (64'(acc) * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      quarter_sine[k] = v[MAG_W-1:0];
    end
  end

  // Short gaps mostly, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Queue the beats of one accepted frame request and advance the phase
  function automatic void expect_frame(input logic req, input logic pinned,
                                       input logic signed [SAMPLE_W-1:0] pin_val);
    logic [1:0]          quad;
    logic [TAB_IDX_W-1:0] slot;
    logic [29:0]         scaled;
    logic [SAMPLE_W-1:0] level;
    int                  nch;
    tone_beat_t          b;
    if (!req) begin
      return;
    end
    quad = tone_phase[31:30];
    slot = {1'b0, tone_phase[29:22]};
    if (quad[0]) begin
      slot = 9'd256 - slot;
    end
    scaled = (30'(quarter_sine[slot]) * 30'(tone_volume)) >> 15;
    level  = {1'b0, scaled[14:0]};
    if (quad[1]) begin
      level = -level;
    end
    if (pinned) begin
      level = pin_val;
    end
    nch = (tone_chans == 0) ? 1 : (int'(tone_chans) > MAX_CH) ? MAX_CH : int'(tone_chans);
    for (int c = 0; c < nch; c++) begin
      b.sample = level;
      b.chan   = CHIDX_W'(c);
      b.last   = (c == nch - 1);
      pending_beats.push_back(b);
    end
    tone_phase = tone_phase + tone_step;
  endfunction

  // Hold a request beat until accepted; valid stays high for a follow-on beat
  task automatic offer(input logic req, input logic pinned,
                       input logic signed [SAMPLE_W-1:0] pin_val);
    in_valid         <= 1'b1;
    in_frame_request <= req;
    do @(posedge clk); while (!in_ready);
    expect_frame(req, pinned, pin_val);
  endtask

  task automatic pause_in(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drain everything outstanding, then idle with the input quiet
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input stg_reg_t idx, input logic [STEP_W-1:0] data);
    settle_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PHASE_STEP:    tone_step   = data;
      REG_VOLUME:        tone_volume = data[VOL_W-1:0];
      REG_CHANNEL_COUNT: tone_chans  = data[CCOUNT_W-1:0];
      default: ;
    endcase
  endtask

  // Stimulus: directed table, then random register settings and request bursts
  initial begin : stimulus
    int          random_frames;
    int          phase_no;
    int          n_items;
    bit          burst;
    logic        req;
    logic [31:0] step_val;
    logic [31:0] vol_val;
    random_frames = 0;
    phase_no      = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_COUNT; r++) begin
      if (DIR_ROWS[r].kind == ROW_WRITE) begin
        write_reg(DIR_ROWS[r].reg_sel, DIR_ROWS[r].wdata);
      end else begin
        offer(DIR_ROWS[r].req, DIR_ROWS[r].pinned, DIR_ROWS[r].pin_val);
        pause_in(idle_gap());
      end
    end

    while (random_frames < RANDOM_FRAMES) begin
      case ($urandom_range(0, 5))
        0:       step_val = 32'd0;
        1:       step_val = 32'hFFFFFFFF;
        2, 3:    step_val = $urandom;
        4:       step_val = $urandom_range(1, 1 << 24);
        default: step_val = {2'($urandom_range(0, 3)), 30'd0} + $urandom_range(0, 4096);
      endcase
      case ($urandom_range(0, 5))
        0:       vol_val = 32'd0;
        1:       vol_val = 32'd32767;
        default: vol_val = $urandom_range(0, 32767);
      endcase
      // upper data bits beyond each register's width are junk and must be dropped
      write_reg(REG_PHASE_STEP, step_val);
      write_reg(REG_VOLUME, ($urandom & 32'hFFFF8000) | vol_val);
      write_reg(REG_CHANNEL_COUNT, ($urandom & 32'hFFFFFFF0) | $urandom_range(0, 15));
      burst   = (phase_no == 1) || ($urandom_range(0, 3) == 0);
      n_items = (phase_no == 1) ? 40 : $urandom_range(15, 40);
      // receiver stalls for a long stretch while this burst keeps coming
      if (phase_no == 1) begin
        squeeze_req = 1'b1;
      end
      for (int i = 0; i < n_items; i++) begin
        req = ($urandom_range(0, 7) != 0);
        offer(req, 1'b0, '0);
        if (req) begin
          random_frames++;
        end
        if (!burst) begin
          pause_in(idle_gap());
        end
      end
      phase_no++;
    end

    settle_idle();
    if (fail_cnt == 0 && pending_beats.size() == 0) begin
      $display("tb_sine_tone_generator_core passed");
    end else begin
      $display("tb_sine_tone_generator_core failed");
    end
    $finish;
  end

  // Receiver ready pattern: random gaps, calm stretches, one long hold-off
  initial begin : rx_side
    int gap;
    int calm_left;
    bit calm;
    calm      = 1'b0;
    calm_left = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        out_ready <= 1'b0;
        repeat (SQUEEZE_HOLD) @(posedge clk);
        squeeze_done = 1'b1;
      end
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(20, 60);
      end
      gap = calm ? 0 : idle_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      calm_left--;
    end
  end

  // Compare every accepted output beat with the oldest expected one
  always @(posedge clk) begin : beat_check
    tone_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      rx_beats++;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat sample %0d chan %0d last %0b", $time,
                 out_sample_value, out_channel_index, out_last_of_frame);
        fail_cnt++;
      end else begin
        want = pending_beats.pop_front();
        if (out_sample_value !== want.sample) begin
          $display("%0t: sample_value expected %0d got %0d", $time,
                   $signed(want.sample), out_sample_value);
          fail_cnt++;
        end
        if (out_channel_index !== want.chan) begin
          $display("%0t: channel_index expected %0d got %0d", $time,
                   want.chan, out_channel_index);
          fail_cnt++;
        end
        if (out_last_of_frame !== want.last) begin
          $display("%0t: last_of_frame expected %0b got %0b", $time,
                   want.last, out_last_of_frame);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats still expected", $time, pending_beats.size());
      $display("tb_sine_tone_generator_core failed");
      $finish;
    end
  end

endmodule
